### src/newton_polynomial_root_defines.svh
// Assertion macros for the checker of the root finder.
// No dependencies.
`ifndef NEWTON_POLYNOMIAL_ROOT_DEFINES_SVH
`define NEWTON_POLYNOMIAL_ROOT_DEFINES_SVH
// Assert that a property holds at every clock edge outside reset.
`define NPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");
// Assert an implication from an antecedent to a consequent.
`define NPR_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`endif

### src/npr_pkg.sv
// Shared types and constants of the polynomial root finder.
// No dependencies.
`default_nettype none
package npr_pkg;
   localparam int NUM_REGS = 8;
   localparam logic [2:0] REG_DEGREE = 3'd0;
   localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

   // Control from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic mul_start;
      logic div_start;
   } npr_ctl_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) sat_add = a[63] ? SAT_MIN : SAT_MAX;
      else sat_add = s;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) sat_sub = a[63] ? SAT_MIN : SAT_MAX;
      else sat_sub = s;
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] v);
      mag = v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] sat_sign(input logic [127:0] m, input logic neg);
      if (neg) begin
         if (m[127:64] != 64'd0 || m[63:0] > SAT_MIN) sat_sign = SAT_MIN;
         else sat_sign = 64'd0 - m[63:0];
      end else begin
         if (m[127:63] != 65'd0) sat_sign = SAT_MAX;
         else sat_sign = m[63:0];
      end
   endfunction
endpackage
`default_nettype wire

### src/npr_arith.sv
// Shared arithmetic unit: 64x64 magnitude multiply in four 32x32 partial
// products over cycles, and a one-bit-per-cycle 128/64 restoring divider.
// Depends on npr_pkg.
`default_nettype none
module npr_arith import npr_pkg::*; #(
   parameter int FRAC_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  npr_ctl_type ctl,
   input  wire  [63:0] op_a,
   input  wire  [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);
   logic        busy_ff, busy_in, is_div_ff, is_div_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic        done_ff, done_in;
   logic [63:0] pp;
   logic [64:0] trial;
   logic [127:0] shifted;

   assign done = done_ff;
   assign result = res_ff;

   always_comb begin
      busy_in = busy_ff; is_div_in = is_div_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; rem_in = rem_ff; res_in = res_ff;
      done_in = 1'b0;
      pp = 64'd0; trial = 65'd0; shifted = 128'd0;
      if (ctl.mul_start || ctl.div_start) begin
         busy_in = 1'b1; is_div_in = ctl.div_start; cnt_in = 8'd0;
         neg_in = op_a[63] ^ op_b[63];
         a_in = mag(op_a); b_in = mag(op_b); rem_in = 64'd0;
         // Dividend for the quotient is |n| shifted up by the fraction width.
         acc_in = ctl.div_start ? ({64'd0, mag(op_a)} << FRAC_BITS) : 128'd0;
      end else if (busy_ff) begin
         if (!is_div_ff) begin
            case (cnt_ff[1:0])
               2'd0: pp = {32'd0, a_ff[31:0]} * {32'd0, b_ff[31:0]};
               2'd1: pp = {32'd0, a_ff[31:0]} * {32'd0, b_ff[63:32]};
               2'd2: pp = {32'd0, a_ff[63:32]} * {32'd0, b_ff[31:0]};
               default: pp = {32'd0, a_ff[63:32]} * {32'd0, b_ff[63:32]};
            endcase
            case (cnt_ff[1:0])
               2'd0: acc_in = acc_ff + {64'd0, pp};
               2'd1, 2'd2: acc_in = acc_ff + ({64'd0, pp} << 32);
               default: acc_in = acc_ff + ({64'd0, pp} << 64);
            endcase
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               busy_in = 1'b0; done_in = 1'b1;
               res_in = sat_sign(acc_in >> FRAC_BITS, neg_ff);
            end
         end else begin
            trial = {rem_ff, acc_ff[127]};
            shifted = {acc_ff[126:0], 1'b0};
            if (trial >= {1'b0, b_ff}) begin
               rem_in = 64'(trial - {1'b0, b_ff});
               shifted[0] = 1'b1;
            end else begin
               rem_in = trial[63:0];
            end
            acc_in = shifted;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd127) begin
               busy_in = 1'b0; done_in = 1'b1;
               res_in = sat_sign(shifted, neg_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 8'd0; is_div_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in; is_div_ff <= is_div_in;
      end
      neg_ff <= neg_in; a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in;
      rem_ff <= rem_in; res_ff <= res_in;
   end
endmodule
`default_nettype wire

### src/newton_polynomial_root.sv
// Newton root finder for a polynomial of degree up to six, fixed point.
// Each Newton step runs 2*deg-1 multiplies on the shared arithmetic unit and then a
// divide; at most MAX_ITERATIONS steps are taken before rsp_valid.
// Throughput: one item at a time; the result register frees the core.
// Reset (synchronous, high) gives degree 1, zero coefficients, idle.
`default_nettype none
module newton_polynomial_root import npr_pkg::*; #(
   parameter int MAX_DEGREE     = 6,
   parameter int MAX_ITERATIONS = 200,
   parameter int FRAC_BITS      = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_start_value,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic        rsp_converged,
   output logic        rsp_slope_zero,
   output logic [7:0]  rsp_steps_used,
   output logic [63:0] rsp_residual,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [63:0] TOL = 64'(((128'd1 << FRAC_BITS) + 128'd500000) / 128'd1000000);
   localparam int SW = $clog2(MAX_ITERATIONS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0, ST_PINIT = 3'd1, ST_PMUL = 3'd2,
                          ST_CHECK = 3'd3, ST_DMUL = 3'd4, ST_DIV = 3'd5,
                          ST_OUT = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  deg_reg_ff;
   logic [15:0] coef_ff [0:6];
   logic [63:0] x_ff, x_in, z_ff, z_in, acc_ff, acc_in;
   logic [2:0]  k_ff, k_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic        conv_ff, conv_in, flat_ff, flat_in;
   logic        ostart_ff, ostart_in;
   logic        rv_ff;
   logic [63:0] rres_ff, rz_ff;
   logic        rc_ff, rf_ff;
   logic [7:0]  rs_ff;
   npr_ctl_type ctl;
   logic [63:0] op_a, op_b, ar;
   logic        adone;
   logic [2:0]  deg;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_result_value = rres_ff;
   assign rsp_converged = rc_ff;
   assign rsp_slope_zero = rf_ff;
   assign rsp_steps_used = rs_ff;
   assign rsp_residual = rz_ff;

   always_comb begin
      deg = deg_reg_ff;
      if (deg == 3'd0) deg = 3'd1;
      if (deg > 3'(MAX_DEGREE)) deg = 3'(MAX_DEGREE);
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_DEGREE: csr_prdata = {29'd0, deg_reg_ff};
         default:    csr_prdata = {{16{coef_ff[csr_paddr[4:2] - 3'd1][15]}},
                                   coef_ff[csr_paddr[4:2] - 3'd1]};
      endcase
   end

   // Integer coefficient times its weight, moved to fixed point with saturation.
   function automatic logic [63:0] fixc(input logic [15:0] c, input logic [2:0] w);
      logic signed [19:0] v;
      logic signed [127:0] f;
      v = $signed(c) * $signed({1'b0, w});
      f = 128'(v) <<< FRAC_BITS;
      if (f > $signed({64'd0, SAT_MAX})) fixc = SAT_MAX;
      else if (f < -$signed({64'd0, SAT_MAX}) - 128'sd1) fixc = SAT_MIN;
      else fixc = f[63:0];
   endfunction

   always_comb begin
      state_in = state_ff; x_in = x_ff; z_in = z_ff; acc_in = acc_ff; k_in = k_ff;
      steps_in = steps_ff; conv_in = conv_ff; flat_in = flat_ff; ostart_in = 1'b0;
      ctl = '0; op_a = acc_ff; op_b = x_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            x_in = req_start_value; steps_in = '0; conv_in = 1'b0; flat_in = 1'b0;
            state_in = ST_PINIT;
         end
         ST_PINIT: begin
            acc_in = fixc(coef_ff[deg], 3'd1); k_in = deg;
            ostart_in = 1'b1; state_in = ST_PMUL;
         end
         ST_PMUL: begin
            ctl.mul_start = ostart_ff;
            if (adone) begin
               acc_in = sat_add(ar, fixc(coef_ff[k_ff - 3'd1], 3'd1));
               k_in = k_ff - 3'd1;
               if (k_ff == 3'd1) state_in = ST_CHECK;
               else ostart_in = 1'b1;
            end
         end
         ST_CHECK: begin
            z_in = acc_ff;
            if (mag(acc_ff) <= TOL) begin
               conv_in = 1'b1; state_in = ST_OUT;
            end else if (steps_ff >= SW'(MAX_ITERATIONS)) begin
               state_in = ST_OUT;
            end else begin
               acc_in = fixc(coef_ff[deg], deg); k_in = deg;
               if (deg == 3'd1) begin
                  state_in = ST_DIV; ostart_in = 1'b1;
               end else begin
                  state_in = ST_DMUL; ostart_in = 1'b1;
               end
            end
         end
         ST_DMUL: begin
            ctl.mul_start = ostart_ff;
            if (adone) begin
               acc_in = sat_add(ar, fixc(coef_ff[k_ff - 3'd1], k_ff - 3'd1));
               k_in = k_ff - 3'd1;
               ostart_in = 1'b1;
               if (k_ff == 3'd2) state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            op_a = z_ff; op_b = acc_ff;
            if (ostart_ff && acc_ff == 64'd0) begin
               flat_in = 1'b1; state_in = ST_OUT;
            end else begin
               ctl.div_start = ostart_ff;
               if (adone) begin
                  x_in = sat_sub(x_ff, ar);
                  steps_in = steps_ff + SW'(1);
                  state_in = ST_PINIT;
               end
            end
         end
         ST_OUT: if (!rv_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   npr_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
      .clock(clock), .reset(reset), .ctl(ctl), .op_a(op_a), .op_b(op_b),
      .done(adone), .result(ar)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rv_ff <= 1'b0; ostart_ff <= 1'b0; deg_reg_ff <= 3'd1;
         for (int i = 0; i < 7; i++) coef_ff[i] <= 16'd0;
      end else begin
         state_ff <= state_in; ostart_ff <= ostart_in;
         if (wr) begin
            if (csr_paddr[4:2] == REG_DEGREE) deg_reg_ff <= csr_pwdata[2:0];
            else coef_ff[csr_paddr[4:2] - 3'd1] <= csr_pwdata[15:0];
         end
         if (state_ff == ST_OUT && (!rv_ff || !rsp_stall)) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
      end
      x_ff <= x_in; z_ff <= z_in; acc_ff <= acc_in; k_ff <= k_in;
      steps_ff <= steps_in; conv_ff <= conv_in; flat_ff <= flat_in;
      if (state_ff == ST_OUT && (!rv_ff || !rsp_stall)) begin
         rres_ff <= x_ff; rz_ff <= z_ff; rc_ff <= conv_ff; rf_ff <= flat_ff;
         rs_ff <= 8'(steps_ff);
      end
   end
endmodule
`default_nettype wire

### src/npr_checker.sv
// Port-level checks of the root finder, bound to the top level.
// Depends on newton_polynomial_root_defines.svh.
`default_nettype none
`include "newton_polynomial_root_defines.svh"
module npr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_converged,
   input wire        rsp_slope_zero,
   input wire [63:0] rsp_result_value
);
   `NPR_ASSERT(a_flags_excl, clock, reset, !(rsp_valid && rsp_converged && rsp_slope_zero))
   `NPR_IMPLY(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid && $stable(rsp_result_value))
   `NPR_IMPLY(a_busy_after_take, clock, reset, req_valid && !req_stall, ##1 req_stall)
endmodule
bind newton_polynomial_root npr_checker u_npr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_converged(rsp_converged),
   .rsp_slope_zero(rsp_slope_zero), .rsp_result_value(rsp_result_value)
);
`default_nettype wire
